// File: hw/rtl/wsak_pkg.sv
`timescale 1ns / 1ps
package wsak_pkg;

    localparam int GUID_LEN   = 36;
    localparam int ACCEPT_LEN = 28;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    // control from the sequencer to the round unit
    typedef struct packed {
        logic start;
    } core_ctl_t;

    // status from the round unit back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } core_sts_t;

    function automatic logic [7:0] guid_char(input logic [5:0] i);
        logic [7:0] c;
        case (i)
            6'd0:  c = "2";
            6'd1:  c = "5";
            6'd2:  c = "8";
            6'd3:  c = "E";
            6'd4:  c = "A";
            6'd5:  c = "F";
            6'd6:  c = "A";
            6'd7:  c = "5";
            6'd8:  c = "-";
            6'd9:  c = "E";
            6'd10: c = "9";
            6'd11: c = "1";
            6'd12: c = "4";
            6'd13: c = "-";
            6'd14: c = "4";
            6'd15: c = "7";
            6'd16: c = "D";
            6'd17: c = "A";
            6'd18: c = "-";
            6'd19: c = "9";
            6'd20: c = "5";
            6'd21: c = "C";
            6'd22: c = "A";
            6'd23: c = "-";
            6'd24: c = "C";
            6'd25: c = "5";
            6'd26: c = "A";
            6'd27: c = "B";
            6'd28: c = "0";
            6'd29: c = "D";
            6'd30: c = "C";
            6'd31: c = "8";
            6'd32: c = "5";
            6'd33: c = "B";
            6'd34: c = "1";
            6'd35: c = "1";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [6:0] b64_char(input logic [5:0] v);
        logic [6:0] c;
        if (v < 6'd26)
            c = 7'd65 + {1'b0, v};
        else if (v < 6'd52)
            c = 7'd71 + {1'b0, v};
        else if (v < 6'd62)
            c = {1'b0, v} - 7'd4;
        else if (v == 6'd62)
            c = 7'd43;
        else
            c = 7'd47;
        return c;
    endfunction

endpackage

// File: hw/rtl/wsak_sha1_core.sv
`timescale 1ns / 1ps
module wsak_sha1_core
    import wsak_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  core_ctl_t    ctl,
    input  logic [511:0] block,
    input  logic [159:0] chain_in,
    output logic [159:0] chain_out,
    output core_sts_t    sts
);

    logic [31:0]  w_reg [16];
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [6:0]   rnd_reg;
    logic         busy_reg, done_reg;
    logic [159:0] chain_out_reg;

    logic [31:0] f, k, t, wnew, wcur;

    // one round per cycle, schedule in a 16-word shift window
    assign wcur = w_reg[0];
    assign wnew = {(w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0])} << 1 |
                  {(w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0])} >> 31;

    always_comb
    begin
        if (rnd_reg < 7'd20)
        begin
            f = (b_reg & c_reg) | (~b_reg & d_reg);
            k = 32'h5A827999;
        end
        else if (rnd_reg < 7'd40)
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = 32'h6ED9EBA1;
        end
        else if (rnd_reg < 7'd60)
        begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k = 32'h8F1BBCDC;
        end
        else
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = 32'hCA62C1D6;
        end
        t = {a_reg[26:0], a_reg[31:27]} + f + e_reg + k + wcur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                rnd_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (rnd_reg == 7'd79)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                rnd_reg <= rnd_reg + 7'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start && !busy_reg)
        begin
            for (int i = 0; i < 16; i++)
                w_reg[i] <= block[511-32*i -: 32];
            a_reg <= chain_in[159:128];
            b_reg <= chain_in[127:96];
            c_reg <= chain_in[95:64];
            d_reg <= chain_in[63:32];
            e_reg <= chain_in[31:0];
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= wnew;
            a_reg <= t;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
        else if (done_reg)
        begin
            chain_out_reg <= {chain_in[159:128] + a_reg, chain_in[127:96] + b_reg,
                              chain_in[95:64] + c_reg, chain_in[63:32] + d_reg,
                              chain_in[31:0] + e_reg};
        end
    end

    assign chain_out = chain_out_reg;
    assign sts.busy  = busy_reg;
    assign sts.done  = done_reg;

endmodule

// File: hw/rtl/websocket_accept_key_gen.sv
`timescale 1ns / 1ps
// channel | dir | tdata            | tuser | tlast
// s_axis  | in  | [7:0] key_byte   | -     | key_last
// m_axis  | out | [6:0] accept_char| -     | char_last
// a key byte is stored as it arrives unless it completes a 64-byte block, which
// then runs 80 rounds on the shared round unit and the add-back before more input
// the last byte triggers guid, padding and one or two more blocks, then 28
// characters leave at one per cycle while m_axis_tready is high
// s_axis_tready is low throughout finishing and character output
// reset clears the sequencer, counters and chain to the sha-1 initial values
module websocket_accept_key_gen
    import wsak_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] key_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] accept_char, [7] zero
    output logic       m_axis_tlast
);

    typedef enum logic [6:0] {
        ST_IN   = 7'b0000001,
        ST_GUID = 7'b0000010,
        ST_PAD  = 7'b0000100,
        ST_CMP  = 7'b0001000,
        ST_WAIT = 7'b0010000,
        ST_ADD  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

    state_t       st_reg;
    state_t       ret_reg;      // state to go to after a block finishes
    logic [511:0] blk_reg;
    logic [159:0] chain_reg;
    logic [63:0]  bits_reg;
    logic [5:0]   pos_reg;
    logic [5:0]   gi_reg;       // guid index
    logic         padded_reg;
    logic         len_here_reg; // the length field goes into the current block
    logic         fin_reg;      // this block is the final one
    logic [4:0]   oi_reg;
    logic [167:0] dig_reg;      // digest plus a zero byte, shifted out 6 bits a beat

    core_ctl_t    ctl;
    core_sts_t    sts;
    logic [159:0] chain_new;

    wsak_sha1_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .block     (blk_reg),
        .chain_in  (chain_reg),
        .chain_out (chain_new),
        .sts       (sts)
    );

    assign ctl.start     = (st_reg == ST_CMP);
    assign s_axis_tready = (st_reg == ST_IN);
    assign m_axis_tvalid = (st_reg == ST_OUT);
    assign m_axis_tdata  = {1'b0, (oi_reg >= 5'd27) ? 7'd61 : b64_char(dig_reg[167:162])};
    assign m_axis_tlast  = (oi_reg == 5'(ACCEPT_LEN - 1));

    logic [7:0] pbyte;
    logic       pad_byte_ok;
    logic       pad_final;

    always_comb
    begin
        // padding byte: 0x80 first, zeros, then the length big-endian
        // the length only goes into the block that can still hold it
        if (!padded_reg)
            pbyte = 8'h80;
        else if (!len_here_reg || (pos_reg < 6'd56))
            pbyte = 8'h00;
        else
            pbyte = bits_reg[8*(7 - pos_reg[2:0]) +: 8];
        pad_byte_ok = 1'b1;
        pad_final   = padded_reg && len_here_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= ST_IN;
            ret_reg      <= ST_IN;
            chain_reg    <= {IV0, IV1, IV2, IV3, IV4};
            bits_reg     <= '0;
            pos_reg      <= '0;
            gi_reg       <= '0;
            padded_reg   <= 1'b0;
            len_here_reg <= 1'b0;
            fin_reg      <= 1'b0;
            oi_reg       <= '0;
        end
        else
        begin
            case (st_reg)
                ST_IN:
                    if (s_axis_tvalid)
                    begin
                        blk_reg[511-8*pos_reg -: 8] <= s_axis_tdata;
                        bits_reg <= bits_reg + 64'd8;
                        pos_reg  <= pos_reg + 6'd1;
                        gi_reg   <= '0;
                        ret_reg  <= s_axis_tlast ? ST_GUID : ST_IN;
                        if (pos_reg == 6'd63)
                            st_reg <= ST_CMP;
                        else if (s_axis_tlast)
                            st_reg <= ST_GUID;
                    end
                ST_GUID:
                begin
                    blk_reg[511-8*pos_reg -: 8] <= guid_char(gi_reg);
                    bits_reg <= bits_reg + 64'd8;
                    pos_reg  <= pos_reg + 6'd1;
                    gi_reg   <= gi_reg + 6'd1;
                    ret_reg  <= (gi_reg == 6'(GUID_LEN - 1)) ? ST_PAD : ST_GUID;
                    if (pos_reg == 6'd63)
                        st_reg <= ST_CMP;
                    else if (gi_reg == 6'(GUID_LEN - 1))
                        st_reg <= ST_PAD;
                end
                ST_PAD:
                    if (pad_byte_ok)
                    begin
                        blk_reg[511-8*pos_reg -: 8] <= pbyte;
                        padded_reg <= 1'b1;
                        pos_reg    <= pos_reg + 6'd1;
                        if (pos_reg == 6'd63)
                        begin
                            // a non-final pad block leaves the length for the next one
                            st_reg       <= ST_CMP;
                            fin_reg      <= pad_final;
                            ret_reg      <= pad_final ? ST_OUT : ST_PAD;
                            len_here_reg <= 1'b1;
                        end
                        else if (!padded_reg)
                            len_here_reg <= (pos_reg < 6'd56);
                    end
                ST_CMP:
                    st_reg <= ST_WAIT;
                ST_WAIT:
                    if (sts.done)
                        st_reg <= ST_ADD;
                ST_ADD:
                begin
                    chain_reg <= chain_new;
                    if (fin_reg)
                    begin
                        dig_reg    <= {chain_new, 8'h00};
                        oi_reg     <= '0;
                        fin_reg    <= 1'b0;
                        padded_reg <= 1'b0;
                        bits_reg   <= '0;
                        pos_reg    <= '0;
                        st_reg     <= ST_OUT;
                    end
                    else
                        st_reg <= ret_reg;
                end
                ST_OUT:
                    if (m_axis_tready)
                    begin
                        dig_reg <= {dig_reg[161:0], 6'd0};
                        oi_reg  <= oi_reg + 5'd1;
                        if (oi_reg == 5'(ACCEPT_LEN - 1))
                        begin
                            chain_reg <= {IV0, IV1, IV2, IV3, IV4};
                            st_reg    <= ST_IN;
                        end
                    end
                default:
                    st_reg <= ST_IN;
            endcase
        end
    end

endmodule
